### src/time_string_parser_assert.svh
// ----------------------------------------------------------------------------
// Time string parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_STRING_PARSER_ASSERT_SVH
`define TIME_STRING_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Time string parser package
// Transaction payload types, parse phases and character codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

   // Character codes used by the parser.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Validity limits of the parsed fields.
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINUTE_MAX = 7'd60;
   localparam logic [6:0] SECOND_MAX = 7'd60;

   // Number of fraction digits that count toward the millisecond.
   localparam logic [1:0] FRAC_DIGITS = 2'd3;

   // Parse phases.
   typedef enum logic [3:0] {
      PH_LEAD      = 4'd0,
      PH_HOUR1     = 4'd1,
      PH_SEP1_PRE  = 4'd2,
      PH_SEP1_POST = 4'd3,
      PH_MIN1      = 4'd4,
      PH_SEP2_PRE  = 4'd5,
      PH_SEP2_POST = 4'd6,
      PH_SEC1      = 4'd7,
      PH_AFTER_SEC = 4'd8,
      PH_FRAC_DOT  = 4'd9,
      PH_FRAC      = 4'd10
   } phase_type;

   // One character of the time string.
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } tsp_req_type;

   // One parse result.
   typedef struct packed {
      logic       ok;
      logic [6:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
      logic [9:0] millisecond;
   } tsp_rsp_type;

endpackage : tsp_pkg

`default_nettype wire

### src/time_string_parser.sv
// ----------------------------------------------------------------------------
// Time string parser
// Parses an hh[:mm[:ss[.fff]]] time string one character per transaction
// and delivers one result transaction on the character marked last.
// A result is valid in the cycle after its last character is accepted.
// One character per cycle unless stalled; the state update is a single pass of
// character decode, phase step and a multiply-by-ten accumulate.
// The result register frees the input side whenever the result is taken or
// empty. Reset (synchronous) clears the phase, accumulators and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "time_string_parser_assert.svh"

module time_string_parser
   import tsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire tsp_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tsp_rsp_type      rsp_data
);

   // Parser state.
   phase_type   phase_ff, phase_in, phase_nx;
   logic [6:0]  hour_ff, hour_in, hour_nx;
   logic [6:0]  minute_ff, minute_in, minute_nx;
   logic [6:0]  second_ff, second_in, second_nx;
   logic [9:0]  fraction_ff, fraction_in, fraction_nx;
   logic [1:0]  count_ff, count_in, count_nx;
   logic        failed_ff, failed_in, failed_nx;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   tsp_rsp_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        is_space;
   logic        is_digit;
   logic        is_delim;
   logic [3:0]  digit;
   logic [9:0]  millisecond;
   logic        values_ok;

   // Handshake: take a character whenever the result register can move.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Character classes.
   assign is_space = (req_data.character == CHAR_SPACE) ||
                     ((req_data.character >= CHAR_TAB) && (req_data.character <= CHAR_CR));
   assign is_digit = (req_data.character >= CHAR_ZERO) && (req_data.character <= CHAR_NINE);
   assign is_delim = (req_data.character == CHAR_COLON) || (req_data.character == CHAR_DOT);
   assign digit    = is_digit ? 4'(req_data.character - CHAR_ZERO) : 4'd0;

   // Next phase and failure flag.
   always_comb begin
      phase_nx  = phase_ff;
      failed_nx = failed_ff;
      if (!failed_ff) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_digit) begin
                  phase_nx = PH_HOUR1;
               end else if (!is_space) begin
                  failed_nx = 1'b1;
               end
            end
            PH_HOUR1: begin
               if (is_digit) phase_nx = PH_SEP1_PRE;
               else failed_nx = 1'b1;
            end
            PH_SEP1_PRE: begin
               if (is_delim) phase_nx = PH_SEP1_POST;
               else if (is_digit) phase_nx = PH_MIN1;
               else if (!is_space) failed_nx = 1'b1;
            end
            PH_SEP1_POST: begin
               if (is_digit) phase_nx = PH_MIN1;
               else if (!is_space) failed_nx = 1'b1;
            end
            PH_MIN1: begin
               if (is_digit) phase_nx = PH_SEP2_PRE;
               else failed_nx = 1'b1;
            end
            PH_SEP2_PRE: begin
               if (is_delim) phase_nx = PH_SEP2_POST;
               else if (is_digit) phase_nx = PH_SEC1;
               else if (!is_space) failed_nx = 1'b1;
            end
            PH_SEP2_POST: begin
               if (is_digit) phase_nx = PH_SEC1;
               else if (!is_space) failed_nx = 1'b1;
            end
            PH_SEC1: begin
               if (is_digit) phase_nx = PH_AFTER_SEC;
               else failed_nx = 1'b1;
            end
            PH_AFTER_SEC: begin
               if (req_data.character == CHAR_DOT) phase_nx = PH_FRAC_DOT;
               else if (is_digit) phase_nx = PH_FRAC;
               else failed_nx = 1'b1;
            end
            PH_FRAC_DOT, PH_FRAC: begin
               if (is_digit) phase_nx = PH_FRAC;
               else failed_nx = 1'b1;
            end
            default: begin
               failed_nx = 1'b1;
            end
         endcase
      end
   end

   // Field accumulators, driven by the current phase and character.
   always_comb begin
      hour_nx     = hour_ff;
      minute_nx   = minute_ff;
      second_nx   = second_ff;
      fraction_nx = fraction_ff;
      count_nx    = count_ff;
      if (!failed_ff && is_digit) begin
         case (phase_ff)
            PH_LEAD: begin
               hour_nx = 7'(digit);
            end
            PH_HOUR1: begin
               hour_nx = 7'(hour_ff * 7'd10) + 7'(digit);
            end
            PH_SEP1_PRE, PH_SEP1_POST: begin
               minute_nx = 7'(digit);
            end
            PH_MIN1: begin
               minute_nx = 7'(minute_ff * 7'd10) + 7'(digit);
            end
            PH_SEP2_PRE, PH_SEP2_POST: begin
               second_nx = 7'(digit);
            end
            PH_SEC1: begin
               second_nx = 7'(second_ff * 7'd10) + 7'(digit);
            end
            PH_AFTER_SEC, PH_FRAC_DOT, PH_FRAC: begin
               // Digits past the third are dropped.
               if (count_ff < FRAC_DIGITS) begin
                  fraction_nx = 10'(fraction_ff * 10'd10) + 10'(digit);
                  count_nx    = count_ff + 2'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Millisecond padding and field range check for the result.
   always_comb begin
      case (count_nx)
         2'd1:    millisecond = 10'(fraction_nx * 10'd100);
         2'd2:    millisecond = 10'(fraction_nx * 10'd10);
         default: millisecond = fraction_nx;
      endcase
   end

   assign values_ok = (hour_nx <= HOUR_MAX) && (minute_nx <= MINUTE_MAX) &&
                      (second_nx <= SECOND_MAX);

   // State next values: the last character returns the parser to its start.
   always_comb begin
      phase_in    = phase_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      fraction_in = fraction_ff;
      count_in    = count_ff;
      failed_in   = failed_ff;
      if (accept) begin
         if (req_data.last) begin
            phase_in    = PH_LEAD;
            hour_in     = '0;
            minute_in   = '0;
            second_in   = '0;
            fraction_in = '0;
            count_in    = '0;
            failed_in   = 1'b0;
         end else begin
            phase_in    = phase_nx;
            hour_in     = hour_nx;
            minute_in   = minute_nx;
            second_in   = second_nx;
            fraction_in = fraction_nx;
            count_in    = count_nx;
            failed_in   = failed_nx;
         end
      end
   end

   // Result next values.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && req_data.last) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.ok          = !failed_nx && (phase_nx != PH_LEAD) &&
                                   (phase_nx != PH_HOUR1) && values_ok;
         rsp_data_in.hour        = hour_nx;
         rsp_data_in.minute      = minute_nx;
         rsp_data_in.second      = second_nx;
         rsp_data_in.millisecond = millisecond;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         fraction_ff  <= '0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         fraction_ff  <= fraction_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // A last character leaves the parser at its start state.
   `TSP_ASSERT_NEXT(a_last_restarts, accept && req_data.last, (phase_ff == PH_LEAD) && !failed_ff && (count_ff == 2'd0), "parser not restarted after last character")

   // A last character always produces a result.
   `TSP_ASSERT_NEXT(a_last_gives_result, accept && req_data.last, rsp_valid_ff, "no result after last character")

   // A held result blocks new characters.
   `TSP_ASSERT_NOW(a_stall_blocks_input, rsp_valid_ff && !rsp_ready, !req_ready, "input open while result stalled")

   // A nonzero fraction digit count occurs only in the fraction phase.
   `TSP_ASSERT_NOW(a_count_in_fraction, count_ff != 2'd0, phase_ff == PH_FRAC, "fraction count outside fraction phase")

endmodule : time_string_parser

`default_nettype wire

### bench/time_string_parser_tb.sv
// ----------------------------------------------------------------------------
// Time string parser testbench
// Drives time strings one character per transaction and checks each result
// against an in-bench parse predictor or a hand-typed result. A short table
// of directed strings comes first, then random strings that are mostly well
// formed. Both sides of the handshake idle at random, with a calm stretch, a
// long receiver hold-off and one full drain of the pipeline in the middle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_string_parser_tb;
   import tsp_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 1000;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned IDLE_PERCENT  = 11;

   // Running state of the predicted parse.
   typedef struct {
      phase_type  phase;
      logic [6:0] hour_sum;
      logic [6:0] minute_sum;
      logic [6:0] second_sum;
      logic [9:0] frac_sum;
      logic [1:0] frac_digits;
      logic       broken;
   } parse_state_type;

   // One directed string, with a hand-written result where it is obvious.
   typedef struct {
      string       text;
      bit          typed;
      tsp_rsp_type want;
   } directed_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tsp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tsp_rsp_type rsp_data;

   parse_state_type parse;
   tsp_rsp_type     pending_results[$];
   logic [7:0]      text_buf[$];
   int unsigned     parsed_chars  = 0;
   int unsigned     error_count   = 0;
   int unsigned     cycle_count   = 0;
   bit              calm          = 1'b0;
   bit              hold_request  = 1'b0;

   directed_row_type directed_rows[6] = '{
      '{"9",             1'b1, '{1'b0, 7'd9,  7'd0,  7'd0,  10'd0}},
      '{" \t",           1'b1, '{1'b0, 7'd0,  7'd0,  7'd0,  10'd0}},
      '{"1x",            1'b1, '{1'b0, 7'd1,  7'd0,  7'd0,  10'd0}},
      '{"23:60:60.9999", 1'b1, '{1'b1, 7'd23, 7'd60, 7'd60, 10'd999}},
      '{"245960.",       1'b1, '{1'b0, 7'd24, 7'd59, 7'd60, 10'd0}},
      '{"1234567",       1'b0, '0}
   };

   time_string_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   // Clears the predicted parse to its idle state.
   function automatic void clear_parse();
      parse.phase       = PH_LEAD;
      parse.hour_sum    = '0;
      parse.minute_sum  = '0;
      parse.second_sum  = '0;
      parse.frac_sum    = '0;
      parse.frac_digits = '0;
      parse.broken      = 1'b0;
   endfunction

   // Steps the predicted parse by one character.
   function automatic void advance_parse(input logic [7:0] c);
      logic       digit;
      logic       blank;
      logic       delim;
      logic [6:0] d;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      delim = (c == CHAR_COLON) || (c == CHAR_DOT);
      d     = digit ? 7'(c - CHAR_ZERO) : 7'd0;
      if (parse.broken) return;
      case (parse.phase)
         PH_LEAD: begin
            if (digit) begin
               parse.hour_sum = d;
               parse.phase    = PH_HOUR1;
            end else if (!blank) begin
               parse.broken = 1'b1;
            end
         end
         PH_HOUR1: begin
            if (digit) begin
               parse.hour_sum = 7'(parse.hour_sum * 10 + d);
               parse.phase    = PH_SEP1_PRE;
            end else begin
               parse.broken = 1'b1;
            end
         end
         PH_SEP1_PRE, PH_SEP2_PRE, PH_SEP1_POST, PH_SEP2_POST: begin
            // A delimiter is taken only once; a digit opens the next field.
            if (blank) begin
            end else if (delim && (parse.phase == PH_SEP1_PRE
                                   || parse.phase == PH_SEP2_PRE)) begin
               parse.phase = phase_type'(parse.phase + 4'd1);
            end else if (digit && (parse.phase == PH_SEP1_PRE
                                   || parse.phase == PH_SEP1_POST)) begin
               parse.minute_sum = d;
               parse.phase      = PH_MIN1;
            end else if (digit) begin
               parse.second_sum = d;
               parse.phase      = PH_SEC1;
            end else begin
               parse.broken = 1'b1;
            end
         end
         PH_MIN1: begin
            if (digit) begin
               parse.minute_sum = 7'(parse.minute_sum * 10 + d);
               parse.phase      = PH_SEP2_PRE;
            end else begin
               parse.broken = 1'b1;
            end
         end
         PH_SEC1: begin
            if (digit) begin
               parse.second_sum = 7'(parse.second_sum * 10 + d);
               parse.phase      = PH_AFTER_SEC;
            end else begin
               parse.broken = 1'b1;
            end
         end
         PH_AFTER_SEC, PH_FRAC_DOT, PH_FRAC: begin
            // Digits beyond the third add nothing to the fraction.
            if (parse.phase == PH_AFTER_SEC && c == CHAR_DOT) begin
               parse.phase = PH_FRAC_DOT;
            end else if (digit) begin
               if (parse.frac_digits < FRAC_DIGITS) begin
                  parse.frac_sum    = 10'(parse.frac_sum * 10 + d);
                  parse.frac_digits = parse.frac_digits + 2'd1;
               end
               parse.phase = PH_FRAC;
            end else begin
               parse.broken = 1'b1;
            end
         end
         default: begin
            parse.broken = 1'b1;
         end
      endcase
   endfunction

   // Forms the result of the finished string and starts a fresh parse.
   function automatic tsp_rsp_type close_parse();
      tsp_rsp_type r;
      int unsigned scale;
      scale = (parse.frac_digits == 2'd1) ? 100 : (parse.frac_digits == 2'd2) ? 10 : 1;
      r.ok = !parse.broken && parse.phase != PH_LEAD && parse.phase != PH_HOUR1
             && parse.hour_sum <= HOUR_MAX && parse.minute_sum <= MINUTE_MAX
             && parse.second_sum <= SECOND_MAX;
      r.hour        = parse.hour_sum;
      r.minute      = parse.minute_sum;
      r.second      = parse.second_sum;
      r.millisecond = 10'(parse.frac_sum * scale);
      clear_parse();
      return r;
   endfunction

   function automatic logic [7:0] random_digit(input int unsigned top);
      if ($urandom_range(0, 3) != 0) return CHAR_ZERO + 8'($urandom_range(0, top));
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_blank();
      if ($urandom_range(0, 1) != 0) return CHAR_SPACE;
      return CHAR_TAB + 8'($urandom_range(0, 4));
   endfunction

   // Builds one random string: mostly well-formed times, some noise and damage.
   function automatic void build_random_text();
      int unsigned field_digits;
      bit          stop;
      text_buf.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) text_buf.push_back(random_blank());
      end
      text_buf.push_back(random_digit(2));
      text_buf.push_back(random_digit(9));
      stop = 1'b0;
      for (int f = 0; f < 2 && !stop; f++) begin
         if ($urandom_range(0, 7) == 0) begin
            stop = 1'b1;
         end else begin
            if ($urandom_range(0, 3) == 0) text_buf.push_back(random_blank());
            if ($urandom_range(0, 3) != 0) begin
               text_buf.push_back(($urandom_range(0, 1) != 0) ? CHAR_COLON : CHAR_DOT);
            end
            if ($urandom_range(0, 3) == 0) text_buf.push_back(random_blank());
            field_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
            if (field_digits > 0) text_buf.push_back(random_digit(6));
            if (field_digits > 1) text_buf.push_back(random_digit(9));
            if (field_digits < 2 && $urandom_range(0, 1) != 0) stop = 1'b1;
         end
      end
      // Optional fraction, with or without its dot.
      if (!stop) begin
         case ($urandom_range(0, 3))
            1: begin
               text_buf.push_back(CHAR_DOT);
            end
            2: begin
               text_buf.push_back(CHAR_DOT);
               repeat ($urandom_range(1, 5)) text_buf.push_back(random_digit(9));
            end
            3: begin
               repeat ($urandom_range(1, 5)) text_buf.push_back(random_digit(9));
            end
            default: begin
            end
         endcase
      end
      // Occasional damage to an otherwise well-formed string.
      if ($urandom_range(0, 7) == 0) begin
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 15) == 0) begin
         text_buf.insert($urandom_range(0, text_buf.size()), random_blank());
      end
   endfunction

   // Offers one character, waits for its transaction and records the prediction.
   task automatic send_char(input logic [7:0] c, input logic last_flag,
                            input bit use_typed, input tsp_rsp_type typed_rsp);
      tsp_rsp_type predicted;
      req_data  <= '{character: c, last: last_flag};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (!parse.broken) parsed_chars++;
      advance_parse(c);
      if (last_flag) begin
         predicted = close_parse();
         pending_results.push_back(use_typed ? typed_rsp : predicted);
      end
      // Outside the calm stretch, the sender idles after about 11 percent of characters.
      if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [9:0] want,
                                input logic [9:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Stimulus: reset, the directed table, then random strings.
   initial begin
      int unsigned string_index;
      int unsigned len;
      clear_parse();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         len = directed_rows[r].text.len();
         for (int i = 0; i < len; i++) begin
            send_char(directed_rows[r].text[i], i == len - 1,
                      directed_rows[r].typed, directed_rows[r].want);
         end
      end

      parsed_chars = 0;
      string_index = 0;
      while (parsed_chars < RANDOM_ITEMS) begin
         calm = (string_index >= 40) && (string_index < 60);
         if (string_index == 10) hold_request = 1'b1;
         if (string_index == 80) drain();
         build_random_text();
         foreach (text_buf[i]) begin
            send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
         end
         string_index++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("time_string_parser test passed");
      end else begin
         $display("time_string_parser test failed");
      end
      $finish;
   end

   // Receiver: random back-pressure, one long hold-off, none while calm.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      tsp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("ok", 10'(want.ok), 10'(rsp_data.ok));
            compare_field("hour", 10'(want.hour), 10'(rsp_data.hour));
            compare_field("minute", 10'(want.minute), 10'(rsp_data.minute));
            compare_field("second", 10'(want.second), 10'(rsp_data.second));
            compare_field("millisecond", want.millisecond, rsp_data.millisecond);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("time_string_parser test failed");
         $finish;
      end
   end

endmodule
